>>> design/tod_pkg.sv
package tod_pkg;

  localparam int CHAR_W = 8;
  localparam int BC_W = 6;
  localparam int SP_CNT_W = 3;
  localparam int BATCH_LIMIT_DEF = 63;

  localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SP = 8'h20;

  localparam logic [CHAR_W-1:0] ERASE_RST = 8'h08;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic REG_CRLF_MODE = 1'b0;
  localparam logic REG_ERASE_CHAR = 1'b1;

  typedef struct packed {
    logic load;
    logic step;
  } tod_cmd_t;

  typedef struct packed {
    logic none;
    logic last;
    logic slot_free;
  } tod_stat_t;

endpackage

>>> design/tod_ctrl.sv
module tod_ctrl import tod_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  tod_stat_t stat,
  output tod_cmd_t  cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN = 1'b1;

  logic state_r;
  logic state_nxt;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (stat.none) begin
          state_nxt = ST_IDLE;
        end else if (stat.slot_free) begin
          cmd.step = 1'b1;
          if (stat.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  a_step_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> stat.slot_free)
    else $error("step issued while the output register is occupied");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(cmd.step && stat.last) |-> in_tready)
    else $error("controller did not return to idle after the final beat");

  a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(cmd.load) |-> !in_tready)
    else $error("controller stayed idle after taking an item");

endmodule

>>> design/tod_dp.sv
module tod_dp import tod_pkg::*; #(
  parameter int BATCH_LIMIT = BATCH_LIMIT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CHAR_W-1:0] in_tdata,
  input  logic              in_tuser,
  input  logic              cfg_valid,
  input  logic              cfg_index,
  input  logic [CHAR_W-1:0] cfg_data,
  input  tod_cmd_t          cmd,
  output tod_stat_t         stat,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [CHAR_W-1:0] out_tdata,
  output logic [2:0]        out_tuser,
  output logic              out_tlast
);

  localparam logic [BC_W-1:0] LIMIT = BC_W'(BATCH_LIMIT);

  logic                crlf_r;
  logic [CHAR_W-1:0]   erase_r;
  logic [CHAR_W-1:0]   column_r;
  logic [BC_W-1:0]     bc_r;
  logic                op_r;
  logic [CHAR_W-1:0]   ch_r;
  logic                phase_r;
  logic [SP_CNT_W-1:0] sp_cnt_r;

  logic                out_valid_r;
  logic [CHAR_W-1:0]   out_char_r;
  logic                out_cvalid_r;
  logic                out_end_r;
  logic                out_single_r;
  logic                out_last_r;

  logic                is_flush;
  logic                is_tab;
  logic                cr_first;
  logic [CHAR_W-1:0]   emit;
  logic [BC_W-1:0]     bc_inc;
  logic                end_w;
  logic                single_w;
  logic [CHAR_W-1:0]   col_upd;
  logic                last_w;

  always_comb begin
    is_flush = (op_r == OP_FLUSH);
    is_tab = (ch_r == CH_TAB);
    cr_first = crlf_r && (ch_r == CH_LF) && !phase_r;
    emit = is_tab ? CH_SP : (cr_first ? CH_CR : ch_r);
    bc_inc = bc_r + BC_W'(1);
    if (is_flush) begin
      end_w = 1'b1;
      single_w = (bc_r == BC_W'(1));
    end else begin
      end_w = (bc_inc == LIMIT) || (emit == CH_LF);
      single_w = end_w && (bc_inc == BC_W'(1));
    end
    priority if ((emit == CH_LF) || (emit == CH_CR)) begin
      col_upd = '0;
    end else if (emit == erase_r) begin
      col_upd = (column_r != '0) ? column_r - CHAR_W'(1) : column_r;
    end else begin
      col_upd = column_r + CHAR_W'(1);
    end
    if (is_flush) begin
      last_w = 1'b1;
    end else if (is_tab) begin
      last_w = (col_upd[2:0] == 3'd0) || (sp_cnt_r == {SP_CNT_W{1'b1}});
    end else begin
      last_w = !cr_first;
    end
  end

  assign stat.none = is_flush ? (bc_r == '0) : (ch_r == CH_NUL);
  assign stat.last = last_w;
  assign stat.slot_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crlf_r <= 1'b1;
      erase_r <= ERASE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CRLF_MODE: crlf_r <= cfg_data[0];
        REG_ERASE_CHAR: erase_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_tuser;
      ch_r <= in_tdata;
      phase_r <= 1'b0;
      sp_cnt_r <= '0;
    end else if (cmd.step) begin
      phase_r <= 1'b1;
      sp_cnt_r <= sp_cnt_r + SP_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= '0;
      bc_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.step) begin
        out_valid_r <= 1'b1;
        bc_r <= end_w ? '0 : bc_inc;
        if (!is_flush) begin
          column_r <= col_upd;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_char_r <= is_flush ? CH_NUL : emit;
      out_cvalid_r <= !is_flush;
      out_end_r <= end_w;
      out_single_r <= single_w;
      out_last_r <= last_w;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_char_r;
  assign out_tuser = {out_single_r, out_end_r, out_cvalid_r};
  assign out_tlast = out_last_r;

  a_bc_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (bc_r < LIMIT))
    else $error("batch count reached the limit without ending the batch");

  a_single_with_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_single_r |-> out_end_r)
    else $error("single-character flag without a batch end");

  a_bare_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_cvalid_r |-> (out_end_r && out_last_r))
    else $error("bare batch end beat is not a final batch end");

endmodule

>>> design/tty_output_discipline.sv
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_tvalid/tready    | tdata[7:0]=char_in, tuser[0]=op
// out_    | output    | out_tvalid/tready   | tdata[7:0]=out_char, tuser, tlast=last
// cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data[7:0]
//
// An item is first taken in, then its result beats follow at one per cycle while the
// output register has room; a tab expands to up to eight spaces, ending on a multiple-of-eight column.
// Items that produce no beat (a zero character or an empty flush) are only taken in.
// The single output register sets the rate; a stalled out_tready holds the sequencer.
// Reset is synchronous and active low; it restores crlf_mode to 1, erase_char to 8,
// and clears the column and the batch count.
module tty_output_discipline import tod_pkg::*; #(
  parameter int BATCH_LIMIT = BATCH_LIMIT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [CHAR_W-1:0] in_tdata,   // [7:0] char_in
  input  logic              in_tuser,   // [0] op
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [CHAR_W-1:0] out_tdata,  // [7:0] out_char
  output logic [2:0]        out_tuser,  // [0] char_valid, [1] batch_end, [2] batch_single
  output logic              out_tlast,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [CHAR_W-1:0] cfg_data
);

  tod_cmd_t  cmd;
  tod_stat_t stat;

  assign cfg_ready = 1'b1;

  tod_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tod_dp #(
    .BATCH_LIMIT (BATCH_LIMIT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
